>>> hw/rtl/rgbyuv_pkg.sv
package rgbyuv_pkg;

   // Fraction bits of the fixed-point coefficients.
   localparam int COEF_FRAC_BITS = 16;
   // Every coefficient magnitude is below one, so it fits with one sign bit.
   localparam int COEF_W = COEF_FRAC_BITS + 1;
   // Three 8-bit by COEF_W products summed, with room for sign and carries.
   localparam int SUM_W = COEF_W + 8 + 3;
   localparam int ACC_W = 10;

   // Rounds micro / 1e6 * 2^COEF_FRAC_BITS half up; evaluated at elaboration.
   function automatic longint quant(input longint micro);
      return ((micro << COEF_FRAC_BITS) + 64'sd500000) / 64'sd1000000;
   endfunction

   localparam logic signed [COEF_W-1:0] COEF_YR = COEF_W'(quant(64'sd299000));
   localparam logic signed [COEF_W-1:0] COEF_YG = COEF_W'(quant(64'sd587000));
   localparam logic signed [COEF_W-1:0] COEF_YB = COEF_W'(quant(64'sd114000));
   localparam logic signed [COEF_W-1:0] COEF_UR = COEF_W'(quant(64'sd147130));
   localparam logic signed [COEF_W-1:0] COEF_UG = COEF_W'(quant(64'sd288860));
   localparam logic signed [COEF_W-1:0] COEF_UB = COEF_W'(quant(64'sd436000));
   localparam logic signed [COEF_W-1:0] COEF_VR = COEF_W'(quant(64'sd615000));
   localparam logic signed [COEF_W-1:0] COEF_VG = COEF_W'(quant(64'sd511499));
   localparam logic signed [COEF_W-1:0] COEF_VB = COEF_W'(quant(64'sd100010));

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       frame_start;
   } pixel_type;

   typedef struct packed {
      logic [7:0] luma;
      logic       chroma_valid;
      logic [7:0] chroma_u;
      logic [7:0] chroma_v;
   } result_type;

   typedef struct packed {
      logic [7:0] y;
      logic [7:0] u;
      logic [7:0] v;
   } yuv_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] u;
      logic [7:0] v;
   } chroma_type;

endpackage

>>> hw/rtl/rgbyuv_color_matrix.sv
module rgbyuv_color_matrix (
   input  rgbyuv_pkg::pixel_type pixel,
   output rgbyuv_pkg::yuv_type   yuv
);

   localparam int SW = rgbyuv_pkg::SUM_W;
   localparam int F  = rgbyuv_pkg::COEF_FRAC_BITS;

   logic signed [SW-1:0] r_ext;
   logic signed [SW-1:0] g_ext;
   logic signed [SW-1:0] b_ext;
   logic signed [SW-1:0] y_sum;
   logic signed [SW-1:0] u_sum;
   logic signed [SW-1:0] v_sum;

   // Floors the weighted sum to an integer and saturates it to 0..255.
   function automatic logic [7:0] clamp8(input logic signed [SW-1:0] sum);
      logic [SW-F-1:0] whole;
      whole = sum[SW-1:F];
      if (sum[SW-1]) begin
         return 8'd0;
      end else if (whole > (SW-F)'(255)) begin
         return 8'd255;
      end else begin
         return whole[7:0];
      end
   endfunction

   assign r_ext = SW'(signed'({1'b0, pixel.red}));
   assign g_ext = SW'(signed'({1'b0, pixel.green}));
   assign b_ext = SW'(signed'({1'b0, pixel.blue}));

   assign y_sum = SW'(rgbyuv_pkg::COEF_YR) * r_ext + SW'(rgbyuv_pkg::COEF_YG) * g_ext
                + SW'(rgbyuv_pkg::COEF_YB) * b_ext;
   assign u_sum = SW'(rgbyuv_pkg::COEF_UB) * b_ext - SW'(rgbyuv_pkg::COEF_UR) * r_ext
                - SW'(rgbyuv_pkg::COEF_UG) * g_ext;
   assign v_sum = SW'(rgbyuv_pkg::COEF_VR) * r_ext - SW'(rgbyuv_pkg::COEF_VG) * g_ext
                - SW'(rgbyuv_pkg::COEF_VB) * b_ext;

   assign yuv.y = clamp8(y_sum);
   assign yuv.u = clamp8(u_sum);
   assign yuv.v = clamp8(v_sum);

endmodule

>>> hw/rtl/rgbyuv_chroma_group.sv
module rgbyuv_chroma_group (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   frame_start,
   input  logic [7:0]             u,
   input  logic [7:0]             v,
   output rgbyuv_pkg::chroma_type chroma
);

   localparam int AW = rgbyuv_pkg::ACC_W;

   logic [1:0]    position_ff;
   logic [1:0]    position_in;
   logic [AW-1:0] u_acc_ff;
   logic [AW-1:0] u_acc_in;
   logic [AW-1:0] v_acc_ff;
   logic [AW-1:0] v_acc_in;
   logic [1:0]    position_now;
   logic [AW-1:0] u_sum;
   logic [AW-1:0] v_sum;
   logic          last_of_group;

   // A frame start drops whatever partial group was collected.
   assign position_now  = frame_start ? 2'd0 : position_ff;
   assign u_sum         = (frame_start ? AW'(0) : u_acc_ff) + AW'(u);
   assign v_sum         = (frame_start ? AW'(0) : v_acc_ff) + AW'(v);
   assign last_of_group = (position_now == 2'd3);

   always_comb begin
      if (last_of_group) begin
         position_in = 2'd0;
         u_acc_in    = '0;
         v_acc_in    = '0;
         chroma.valid = 1'b1;
         chroma.u     = u_sum[AW-1:2];
         chroma.v     = v_sum[AW-1:2];
      end else begin
         position_in = position_now + 2'd1;
         u_acc_in    = u_sum;
         v_acc_in    = v_sum;
         chroma.valid = 1'b0;
         chroma.u     = 8'd0;
         chroma.v     = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= 2'd0;
         u_acc_ff    <= '0;
         v_acc_ff    <= '0;
      end else if (advance) begin
         position_ff <= position_in;
         u_acc_ff    <= u_acc_in;
         v_acc_ff    <= v_acc_in;
      end
   end

endmodule

>>> hw/rtl/rgb_to_yuv411_converter_top.sv
// Channel   Ports                          Direction  Moves
// request   req_valid req_ready req_pixel  in         one RGB pixel and frame-start flag
// result    rsp_valid rsp_ready rsp_result out        Y, and U/V on every fourth pixel
//
// A request is registered in the input register when accepted, converted and
// grouped from there, and its result is registered in the output register once
// that register is free; rsp_valid rises when the result is registered.
// One request per cycle is taken while the result side keeps up.
// Reset clears both stage valid flags and the group position and sums.
// A stalled result holds both stages; a request is still taken while the
// input register is empty or moving on.
module rgb_to_yuv411_converter_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  rgbyuv_pkg::pixel_type  req_pixel,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rgbyuv_pkg::result_type rsp_result
);

   logic                   in_valid_ff;
   rgbyuv_pkg::pixel_type  in_pixel_ff;
   logic                   out_valid_ff;
   logic                   out_valid_in;
   rgbyuv_pkg::result_type out_result_ff;
   rgbyuv_pkg::result_type out_result_in;
   rgbyuv_pkg::yuv_type    yuv;
   rgbyuv_pkg::chroma_type chroma;
   logic                   out_free;
   logic                   advance;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   rgbyuv_color_matrix u_matrix (
      .pixel (in_pixel_ff),
      .yuv   (yuv)
   );

   rgbyuv_chroma_group u_group (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .frame_start (in_pixel_ff.frame_start),
      .u           (yuv.u),
      .v           (yuv.v),
      .chroma      (chroma)
   );

   always_comb begin
      out_result_in.luma         = yuv.y;
      out_result_in.chroma_valid = chroma.valid;
      out_result_in.chroma_u     = chroma.u;
      out_result_in.chroma_v     = chroma.v;
      out_valid_in = advance ? 1'b1 : (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         out_valid_ff <= out_valid_in;
      end
      if (req_ready && req_valid) begin
         in_pixel_ff <= req_pixel;
      end
      if (advance) begin
         out_result_ff <= out_result_in;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_result = out_result_ff;

endmodule

>>> tb/tb_rgb_to_yuv411_converter_top.sv
module tb_rgb_to_yuv411_converter_top;

   // Coefficient in millionths to signed fixed point, rounded half up.
   function automatic longint to_fixed(input longint millionths);
      longint scaled;
      scaled = millionths * (longint'(1) << rgbyuv_pkg::COEF_FRAC_BITS);
      return (scaled + 500000) / 1000000;
   endfunction

   localparam longint K_YR = to_fixed(299000);
   localparam longint K_YG = to_fixed(587000);
   localparam longint K_YB = to_fixed(114000);
   localparam longint K_UR = to_fixed(147130);
   localparam longint K_UG = to_fixed(288860);
   localparam longint K_UB = to_fixed(436000);
   localparam longint K_VR = to_fixed(615000);
   localparam longint K_VG = to_fixed(511499);
   localparam longint K_VB = to_fixed(100010);

   localparam int LONG_HOLD_CYCLES = 200;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   rgbyuv_pkg::pixel_type  req_pixel;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rgbyuv_pkg::result_type rsp_result;

   rgbyuv_pkg::result_type pending_results[$];
   int         mismatch_count = 0;

   // Grouping state of the predictor.
   logic [1:0] grp_count;
   logic [9:0] u_sum;
   logic [9:0] v_sum;

   // Idle controls shared by the tests and the receiver.
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   bit hold_request = 1'b0;
   int stall_left = 0;

   rgb_to_yuv411_converter_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_pixel  (req_pixel),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (rsp_result)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] floor_sat8(input longint weighted);
      longint whole;
      if (weighted < 0) begin
         return 8'd0;
      end
      whole = weighted >>> rgbyuv_pkg::COEF_FRAC_BITS;
      return (whole > 255) ? 8'd255 : whole[7:0];
   endfunction

   function automatic rgbyuv_pkg::result_type convert_pixel(
      input rgbyuv_pkg::pixel_type p);
      longint     r, g, b;
      logic [7:0] y, u, v;
      logic [9:0] next_u, next_v;
      rgbyuv_pkg::result_type res;
      r = longint'(p.red);
      g = longint'(p.green);
      b = longint'(p.blue);
      y = floor_sat8(K_YR * r + K_YG * g + K_YB * b);
      u = floor_sat8(-K_UR * r - K_UG * g + K_UB * b);
      v = floor_sat8(K_VR * r - K_VG * g - K_VB * b);
      if (p.frame_start) begin
         grp_count = 2'd0;
         u_sum = 10'd0;
         v_sum = 10'd0;
      end
      next_u = u_sum + 10'(u);
      next_v = v_sum + 10'(v);
      res = '0;
      res.luma = y;
      if (grp_count == 2'd3) begin
         res.chroma_valid = 1'b1;
         res.chroma_u = next_u[9:2];
         res.chroma_v = next_v[9:2];
         grp_count = 2'd0;
         u_sum = 10'd0;
         v_sum = 10'd0;
      end else begin
         grp_count = grp_count + 2'd1;
         u_sum = next_u;
         v_sum = next_v;
      end
      return res;
   endfunction

   // Mostly back to back, often a short gap, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end else if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic rgbyuv_pkg::pixel_type make_pixel(
      input logic [7:0] r, input logic [7:0] g, input logic [7:0] b, input logic fs);
      rgbyuv_pkg::pixel_type p;
      p.red = r;
      p.green = g;
      p.blue = b;
      p.frame_start = fs;
      return p;
   endfunction

   function automatic logic [7:0] random_sample();
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      end
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic rgbyuv_pkg::pixel_type random_pixel(input logic fs);
      return make_pixel(random_sample(), random_sample(), random_sample(), fs);
   endfunction

   // The receiver: random stalls, plus one long hold when a test asks for it.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (hold_request) begin
         hold_request <= 1'b0;
         rsp_ready <= 1'b0;
         stall_left <= LONG_HOLD_CYCLES;
      end else if (rsp_idle_on && $urandom_range(0, 3) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= pick_gap();
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      rgbyuv_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result with nothing expected, actual %h", $time, rsp_result);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_result.luma !== want.luma) begin
               $display("%0t: luma expected %h actual %h", $time, want.luma,
                        rsp_result.luma);
               mismatch_count++;
            end
            if (rsp_result.chroma_valid !== want.chroma_valid) begin
               $display("%0t: chroma_valid expected %h actual %h", $time,
                        want.chroma_valid, rsp_result.chroma_valid);
               mismatch_count++;
            end
            if (rsp_result.chroma_u !== want.chroma_u) begin
               $display("%0t: chroma_u expected %h actual %h", $time, want.chroma_u,
                        rsp_result.chroma_u);
               mismatch_count++;
            end
            if (rsp_result.chroma_v !== want.chroma_v) begin
               $display("%0t: chroma_v expected %h actual %h", $time, want.chroma_v,
                        rsp_result.chroma_v);
               mismatch_count++;
            end
         end
      end
   end

   // Called at a rising edge. The valid stays high after acceptance unless a gap
   // follows, so the next request can go out in the very next cycle.
   task automatic send_pixel(input rgbyuv_pkg::pixel_type p);
      int gap;
      req_valid <= 1'b1;
      req_pixel <= p;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(convert_pixel(p));
      gap = req_idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic test_directed();
      // Extremes of each channel in one group.
      send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 1'b1));
      send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 1'b0));
      send_pixel(make_pixel(8'd255, 8'd0, 8'd0, 1'b0));
      send_pixel(make_pixel(8'd0, 8'd255, 8'd0, 1'b0));
      // Largest U from pure blue, then magenta, each over a full group.
      repeat (4) send_pixel(make_pixel(8'd0, 8'd0, 8'd255, 1'b0));
      repeat (4) send_pixel(make_pixel(8'd255, 8'd0, 8'd255, 1'b0));
      // A frame start in mid-group throws the partial group away.
      send_pixel(make_pixel(8'd0, 8'd0, 8'd255, 1'b1));
      send_pixel(make_pixel(8'd255, 8'd0, 8'd0, 1'b0));
      send_pixel(make_pixel(8'd0, 8'd255, 8'd0, 1'b1));
      send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 1'b0));
      send_pixel(make_pixel(8'd0, 8'd0, 8'd255, 1'b0));
      send_pixel(make_pixel(8'd255, 8'd0, 8'd255, 1'b0));
      // Frame start on several pixels in a row, then one on the fourth position.
      repeat (3) send_pixel(make_pixel(8'd255, 8'd0, 8'd255, 1'b1));
      send_pixel(make_pixel(8'd128, 8'd64, 8'd200, 1'b0));
      send_pixel(make_pixel(8'd255, 8'd0, 8'd0, 1'b0));
      send_pixel(make_pixel(8'd1, 8'd2, 8'd254, 1'b1));
      send_pixel(make_pixel(8'd254, 8'd1, 8'd3, 1'b0));
   endtask

   task automatic test_random_frames(input int count);
      int done;
      int frame_len;
      bit noisy;
      done = 0;
      while (done < count) begin
         noisy = ($urandom_range(0, 9) == 0);
         if ($urandom_range(0, 4) == 0) begin
            frame_len = $urandom_range(1, 15);
         end else begin
            frame_len = 4 * $urandom_range(1, 8);
         end
         // Some frames run with no idling on either side.
         req_idle_on = ($urandom_range(0, 4) != 0);
         rsp_idle_on = req_idle_on;
         for (int i = 0; i < frame_len; i++) begin
            if (noisy) begin
               send_pixel(random_pixel($urandom_range(0, 3) == 0));
            end else begin
               send_pixel(random_pixel(i == 0));
            end
            done++;
         end
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   // The receiver holds off while requests keep coming, so the block fills and
   // stalls its input.
   task automatic test_backpressure();
      req_idle_on = 1'b0;
      hold_request = 1'b1;
      for (int i = 0; i < 48; i++) begin
         send_pixel(random_pixel(i == 0));
      end
      req_idle_on = 1'b1;
   endtask

   // The sender stops mid-group until every result is back, then resumes.
   task automatic test_pause_and_resume();
      for (int i = 0; i < 10; i++) begin
         send_pixel(random_pixel(i == 0));
      end
      wait_drained();
      for (int i = 0; i < 10; i++) begin
         send_pixel(random_pixel(1'b0));
      end
      wait_drained();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_pixel = '0;
      grp_count = 2'd0;
      u_sum = 10'd0;
      v_sum = 10'd0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_frames(260);
      test_backpressure();
      test_pause_and_resume();
      test_random_frames(260);
      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_rgb_to_yuv411_converter_top: done, clean");
      end else begin
         $display("tb_rgb_to_yuv411_converter_top: done, errors");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb_rgb_to_yuv411_converter_top: done, errors");
      $finish;
   end

endmodule
